>>> sv/ddpc_pkg.sv
`default_nettype none

package ddpc_pkg;

	// Datapath sizing.
	localparam int COUNT_BITS          = 24;
	localparam int GAIN_FRAC_BITS      = 8;
	localparam int STRAIGHT_BASE_POWER = 60;

	// Fixed field widths.
	localparam int GAIN_W          = 16;
	localparam int SCALE_W         = 16;
	localparam int SCALE_FRAC_BITS = 8;
	localparam int AMOUNT_W        = 16;
	localparam int TARGET_W        = 23;
	localparam int POWER_W         = 7;
	localparam int MODE_W          = 3;
	localparam int DIR_W           = 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int INTEG_W         = 11;

	// Derived widths.
	localparam int ERR_W      = COUNT_BITS + 1;
	localparam int DERR_W     = COUNT_BITS + 2;
	localparam int PROD_W     = GAIN_W + DERR_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int TGT_PROD_W = AMOUNT_W + SCALE_W;
	localparam int TGT_SHR_W  = TGT_PROD_W - SCALE_FRAC_BITS;
	localparam int CMP_W      = ((COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W) + 1;

	// Constants.
	localparam int INTEG_LIMIT = 1000;
	localparam int POWER_MIN   = 70;
	localparam int POWER_MAX   = 100;
	localparam int POWER_RESET = 80;
	localparam int HALF_SHIFT  = GAIN_FRAC_BITS + 1;
	localparam int HALF_BIAS   = (2 ** HALF_SHIFT) - 1;
	localparam int SCALE_RESET = 256;
	localparam logic [TARGET_W-1:0] TARGET_MAX = '1;

	typedef enum logic [MODE_W-1:0] {
		MODE_FORWARD    = 3'd0,
		MODE_BACK       = 3'd1,
		MODE_TURN_LEFT  = 3'd2,
		MODE_TURN_RIGHT = 3'd3,
		MODE_LEFT       = 3'd4,
		MODE_RIGHT      = 3'd5,
		MODE_STOP       = 3'd6
	} mode_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_STOPPED = 2'd0,
		DIR_CW      = 2'd1,
		DIR_CCW     = 2'd2
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADING_GAIN_P = 3'd0,
		REG_HEADING_GAIN_D = 3'd1,
		REG_HEADING_GAIN_I = 3'd2,
		REG_TOTAL_GAIN_P   = 3'd3,
		REG_STRAIGHT_SCALE = 3'd4,
		REG_TURN_SCALE     = 3'd5
	} cfg_reg_t;

	// One input item as captured at the input register.
	typedef struct packed {
		logic                         action;
		logic [MODE_W-1:0]            move_kind;
		logic [AMOUNT_W-1:0]          amount;
		logic signed [COUNT_BITS-1:0] count_left;
		logic signed [COUNT_BITS-1:0] count_right;
	} cmd_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] p;
		logic signed [GAIN_W-1:0] d;
		logic signed [GAIN_W-1:0] i;
		logic signed [GAIN_W-1:0] t;
	} gains_t;

	// Control and held values that travel with an item down the pipeline.
	typedef struct packed {
		logic                         pid_en;
		logic                         straight;
		dir_t                         dir_l;
		dir_t                         dir_r;
		logic [MODE_W-1:0]            mode;
		logic [TARGET_W-1:0]          target;
		logic signed [COUNT_BITS-1:0] progress;
		logic                         done;
		logic                         clear;
	} ctl_t;

	typedef struct packed {
		ctl_t                      ctl;
		logic signed [ERR_W-1:0]   err;
		logic signed [DERR_W-1:0]  derr;
		logic signed [ERR_W-1:0]   etot;
		logic signed [INTEG_W-1:0] integ;
	} trk_t;

	typedef struct packed {
		ctl_t                     ctl;
		logic signed [PROD_W-1:0] prod_p;
		logic signed [PROD_W-1:0] prod_d;
		logic signed [PROD_W-1:0] prod_t;
		logic signed [PROD_W-1:0] prod_i;
	} mul_t;

	typedef struct packed {
		dir_t                         dir_l;
		dir_t                         dir_r;
		logic [POWER_W-1:0]           power_l;
		logic [POWER_W-1:0]           power_r;
		logic [MODE_W-1:0]            mode;
		logic [TARGET_W-1:0]          target;
		logic signed [COUNT_BITS-1:0] progress;
		logic                         done;
		logic                         clear;
	} res_t;

endpackage

`default_nettype wire

>>> sv/ddpc_ifs.sv
`default_nettype none

// Command and tick channel.
interface ddpc_cmd_if;
	import ddpc_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [MODE_W-1:0]            move_kind;
	logic [AMOUNT_W-1:0]          amount;
	logic signed [COUNT_BITS-1:0] count_left;
	logic signed [COUNT_BITS-1:0] count_right;

	modport source (output valid, action, move_kind, amount, count_left, count_right,
		input ready);
	modport sink (input valid, action, move_kind, amount, count_left, count_right,
		output ready);
endinterface

// Result channel.
interface ddpc_res_if;
	import ddpc_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [DIR_W-1:0]             dir_left;
	logic [DIR_W-1:0]             dir_right;
	logic [POWER_W-1:0]           power_left;
	logic [POWER_W-1:0]           power_right;
	logic [MODE_W-1:0]            mode_now;
	logic [TARGET_W-1:0]          target_counts;
	logic signed [COUNT_BITS-1:0] progress_counts;
	logic                         move_done;
	logic                         reset_encoders;

	modport source (output valid, dir_left, dir_right, power_left, power_right, mode_now,
		target_counts, progress_counts, move_done, reset_encoders, input ready);
	modport sink (input valid, dir_left, dir_right, power_left, power_right, mode_now,
		target_counts, progress_counts, move_done, reset_encoders, output ready);
endinterface

// Configuration write channel.
interface ddpc_cfg_if;
	import ddpc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/ddpc_track.sv
`default_nettype none

module ddpc_track (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  ddpc_pkg::cmd_t                    item,
	input  wire logic [ddpc_pkg::SCALE_W-1:0] straight_scale,
	input  wire logic [ddpc_pkg::SCALE_W-1:0] turn_scale,
	output ddpc_pkg::trk_t                    trk_s2
);
	import ddpc_pkg::*;

	mode_t                        mode_q, mode_n;
	logic [TARGET_W-1:0]          target_q, target_n;
	logic signed [COUNT_BITS-1:0] progress_q, progress_n;
	logic                         done_q, done_n;
	logic signed [COUNT_BITS-1:0] last_l_q, last_l_n;
	logic signed [COUNT_BITS-1:0] last_r_q, last_r_n;
	logic signed [ERR_W-1:0]      last_err_q, last_err_n;
	logic signed [INTEG_W-1:0]    integ_q, integ_n;
	dir_t                         dir_l_q, dir_l_n;
	dir_t                         dir_r_q, dir_r_n;

	logic [SCALE_W-1:0]           scale_sel;
	logic [TGT_PROD_W-1:0]        tgt_prod;
	logic [TGT_SHR_W-1:0]         tgt_shr;
	logic [TARGET_W-1:0]          tgt_sat;
	logic signed [COUNT_BITS-1:0] dl, dr, mean;
	logic signed [COUNT_BITS:0]   cnt_sum, cnt_adj;
	logic signed [ERR_W-1:0]      err, etot;
	logic signed [DERR_W-1:0]     derr;
	logic signed [ERR_W:0]        integ_sum;
	logic                         straight, reached, pid_en, clear;

	// Target of a move command: amount times the Q8.8 scale, saturated.
	always_comb begin
		if (item.move_kind == MODE_TURN_LEFT || item.move_kind == MODE_TURN_RIGHT) begin
			scale_sel = turn_scale;
		end else begin
			scale_sel = straight_scale;
		end
		tgt_prod = TGT_PROD_W'(item.amount) * TGT_PROD_W'(scale_sel);
		tgt_shr  = tgt_prod[TGT_PROD_W-1:SCALE_FRAC_BITS];
		if (tgt_shr > TGT_SHR_W'(TARGET_MAX)) begin
			tgt_sat = TARGET_MAX;
		end else begin
			tgt_sat = tgt_shr[TARGET_W-1:0];
		end
	end

	// Wheel deltas, mean count and heading error terms of a tick.
	always_comb begin
		straight = (mode_q == MODE_FORWARD) || (mode_q == MODE_BACK);
		dl       = item.count_left - last_l_q;
		dr       = item.count_right - last_r_q;
		err      = ERR_W'(dr) - ERR_W'(dl);
		derr     = DERR_W'(err) - DERR_W'(last_err_q);
		if (straight) begin
			etot = ERR_W'(item.count_right) - ERR_W'(item.count_left);
		end else begin
			etot = '0;
		end
		// The mean truncates toward zero: bias negative sums up by one before the shift.
		cnt_sum = (COUNT_BITS+1)'(item.count_left) + (COUNT_BITS+1)'(item.count_right);
		cnt_adj = cnt_sum + $signed({{COUNT_BITS{1'b0}}, cnt_sum[COUNT_BITS]});
		mean    = cnt_adj[COUNT_BITS:1];
		reached = CMP_W'(mean) >= $signed(CMP_W'(target_q));
		// Anti-windup clamp on the integral.
		integ_sum = (ERR_W+1)'(integ_q) + (ERR_W+1)'(err);
		if (integ_sum > (ERR_W+1)'(INTEG_LIMIT)) begin
			integ_n = INTEG_W'(INTEG_LIMIT);
		end else if (integ_sum < (ERR_W+1)'(-INTEG_LIMIT)) begin
			integ_n = INTEG_W'(-INTEG_LIMIT);
		end else begin
			integ_n = INTEG_W'(integ_sum);
		end
	end

	// Next state of the move tracker.
	always_comb begin
		mode_n     = mode_q;
		target_n   = target_q;
		progress_n = progress_q;
		done_n     = done_q;
		last_l_n   = last_l_q;
		last_r_n   = last_r_q;
		last_err_n = last_err_q;
		dir_l_n    = dir_l_q;
		dir_r_n    = dir_r_q;
		pid_en     = 1'b0;
		clear      = 1'b0;
		if (item.action) begin
			done_n = 1'b0;
			if (item.move_kind == MODE_STOP) begin
				mode_n = MODE_STOP;
			end else if (item.move_kind < MODE_STOP) begin
				mode_n   = mode_t'(item.move_kind);
				target_n = tgt_sat;
			end
		end else begin
			case (mode_q) inside
				MODE_STOP: begin
					dir_l_n = DIR_STOPPED;
					dir_r_n = DIR_STOPPED;
				end
				MODE_FORWARD, MODE_BACK, MODE_TURN_LEFT, MODE_TURN_RIGHT: begin
					if (reached) begin
						mode_n     = MODE_STOP;
						target_n   = '0;
						progress_n = '0;
						last_l_n   = '0;
						last_r_n   = '0;
						done_n     = 1'b1;
						clear      = 1'b1;
					end else begin
						last_l_n   = item.count_left;
						last_r_n   = item.count_right;
						progress_n = mean;
						last_err_n = err;
						pid_en     = 1'b1;
						case (mode_q)
							MODE_FORWARD: begin
								dir_r_n = DIR_CW;
								dir_l_n = DIR_CCW;
							end
							MODE_BACK: begin
								dir_r_n = DIR_CCW;
								dir_l_n = DIR_CW;
							end
							MODE_TURN_LEFT: begin
								dir_r_n = DIR_CW;
								dir_l_n = DIR_CW;
							end
							default: begin
								dir_r_n = DIR_CCW;
								dir_l_n = DIR_CCW;
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_STOP;
			target_q   <= '0;
			progress_q <= '0;
			done_q     <= 1'b0;
			last_l_q   <= '0;
			last_r_q   <= '0;
			last_err_q <= '0;
			integ_q    <= '0;
			dir_l_q    <= DIR_STOPPED;
			dir_r_q    <= DIR_STOPPED;
		end else if (step) begin
			mode_q     <= mode_n;
			target_q   <= target_n;
			progress_q <= progress_n;
			done_q     <= done_n;
			last_l_q   <= last_l_n;
			last_r_q   <= last_r_n;
			last_err_q <= last_err_n;
			if (pid_en) begin
				integ_q <= integ_n;
			end
			dir_l_q    <= dir_l_n;
			dir_r_q    <= dir_r_n;
		end
	end

	// Stage 2 register: held values after this item plus the PID terms.
	always_ff @(posedge clk) begin
		if (step) begin
			trk_s2.ctl.pid_en   <= pid_en;
			trk_s2.ctl.straight <= straight;
			trk_s2.ctl.dir_l    <= dir_l_n;
			trk_s2.ctl.dir_r    <= dir_r_n;
			trk_s2.ctl.mode     <= mode_n;
			trk_s2.ctl.target   <= target_n;
			trk_s2.ctl.progress <= progress_n;
			trk_s2.ctl.done     <= done_n;
			trk_s2.ctl.clear    <= clear;
			trk_s2.err          <= err;
			trk_s2.derr         <= derr;
			trk_s2.etot         <= etot;
			trk_s2.integ        <= integ_n;
		end
	end

endmodule

`default_nettype wire

>>> sv/ddpc_mult.sv
`default_nettype none

module ddpc_mult (
	input  wire logic      clk,
	input  wire logic      load,
	input  ddpc_pkg::gains_t gains,
	input  ddpc_pkg::trk_t   trk_s2,
	output ddpc_pkg::mul_t   mul_s3
);
	import ddpc_pkg::*;

	// Four gain products in parallel, registered before the sum.
	always_ff @(posedge clk) begin
		if (load) begin
			mul_s3.ctl    <= trk_s2.ctl;
			mul_s3.prod_p <= PROD_W'(gains.p) * PROD_W'(trk_s2.err);
			mul_s3.prod_d <= PROD_W'(gains.d) * PROD_W'(trk_s2.derr);
			mul_s3.prod_t <= PROD_W'(gains.t) * PROD_W'(trk_s2.etot);
			mul_s3.prod_i <= PROD_W'(gains.i) * PROD_W'(trk_s2.integ);
		end
	end

endmodule

`default_nettype wire

>>> sv/ddpc_power.sv
`default_nettype none

module ddpc_power (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  ddpc_pkg::mul_t mul_s3,
	output ddpc_pkg::res_t res_q
);
	import ddpc_pkg::*;

	logic [POWER_W-1:0]      power_l_q, power_r_q;
	logic [POWER_W-1:0]      power_l_n, power_r_n;
	logic signed [SUM_W-1:0] sum, sum_adj, half, base_l, base_r, new_l, new_r;

	// Correction sum, halved toward zero, split over the two wheels and clamped.
	always_comb begin
		sum = SUM_W'(mul_s3.prod_p) + SUM_W'(mul_s3.prod_d)
			+ SUM_W'(mul_s3.prod_t) + SUM_W'(mul_s3.prod_i);
		if (sum < 0) begin
			sum_adj = sum + SUM_W'(HALF_BIAS);
		end else begin
			sum_adj = sum;
		end
		half = sum_adj >>> HALF_SHIFT;
		if (mul_s3.ctl.straight) begin
			base_l = SUM_W'(STRAIGHT_BASE_POWER);
			base_r = SUM_W'(STRAIGHT_BASE_POWER);
		end else begin
			base_l = $signed(SUM_W'(power_l_q));
			base_r = $signed(SUM_W'(power_r_q));
		end
		new_l = base_l + half;
		new_r = base_r - half;
		if (new_l < SUM_W'(POWER_MIN)) begin
			power_l_n = POWER_W'(POWER_MIN);
		end else if (new_l > SUM_W'(POWER_MAX)) begin
			power_l_n = POWER_W'(POWER_MAX);
		end else begin
			power_l_n = new_l[POWER_W-1:0];
		end
		if (new_r < SUM_W'(POWER_MIN)) begin
			power_r_n = POWER_W'(POWER_MIN);
		end else if (new_r > SUM_W'(POWER_MAX)) begin
			power_r_n = POWER_W'(POWER_MAX);
		end else begin
			power_r_n = new_r[POWER_W-1:0];
		end
		if (!mul_s3.ctl.pid_en) begin
			power_l_n = power_l_q;
			power_r_n = power_r_q;
		end
	end

	// Held motor powers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_l_q <= POWER_W'(POWER_RESET);
			power_r_q <= POWER_W'(POWER_RESET);
		end else if (load) begin
			power_l_q <= power_l_n;
			power_r_q <= power_r_n;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.dir_l    <= mul_s3.ctl.dir_l;
			res_q.dir_r    <= mul_s3.ctl.dir_r;
			res_q.power_l  <= power_l_n;
			res_q.power_r  <= power_r_n;
			res_q.mode     <= mul_s3.ctl.mode;
			res_q.target   <= mul_s3.ctl.target;
			res_q.progress <= mul_s3.ctl.progress;
			res_q.done     <= mul_s3.ctl.done;
			res_q.clear    <= mul_s3.ctl.clear;
		end
	end

endmodule

`default_nettype wire

>>> sv/differential_drive_pid_control_top.sv
// Move controller for a two-motor differential drive. A command transfer
// (action 1) selects the movement mode and sets the target in encoder counts;
// a tick transfer (action 0) brings both encoder counts and, in a forward,
// back or turn move, updates the heading PID, the motor powers (clamped to
// 70..100) and the directions, and ends the move with move_done and a
// one-result reset_encoders pulse once the mean count reaches the target.
// Every input transfer yields exactly one result, in order. The block takes
// one item per clock cycle while cmd.ready is high; each result passes an
// input register, the move tracker stage, the gain multiplier stage and the
// result register. When the result register is full and not taken, the stall
// reaches cmd.ready in the same cycle only once all four stages hold an item.
// Configuration registers are written through cfg at any time with cfg.ready
// always high, but should change only while no item is in flight.
`default_nettype none

module differential_drive_pid_control_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ddpc_cmd_if.sink    cmd,
	ddpc_res_if.source  res,
	ddpc_cfg_if.sink    cfg
);
	import ddpc_pkg::*;

	logic               v1_q, v2_q, v3_q, vo_q;
	logic               rdy2, rdy3, adv_o;
	cmd_t               item_s1;
	trk_t               trk_s2;
	mul_t               mul_s3;
	res_t               res_q;
	gains_t             gains_q;
	logic [SCALE_W-1:0] straight_scale_q, turn_scale_q;

	// Pipeline advance: a stage takes a new item when empty or when it moves on.
	assign adv_o     = !vo_q || res.ready;
	assign rdy3      = !v3_q || adv_o;
	assign rdy2      = !v2_q || rdy3;
	assign cmd.ready = !v1_q || rdy2;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				v1_q <= cmd.valid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (adv_o) begin
				vo_q <= v3_q;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.action      <= cmd.action;
			item_s1.move_kind   <= cmd.move_kind;
			item_s1.amount      <= cmd.amount;
			item_s1.count_left  <= cmd.count_left;
			item_s1.count_right <= cmd.count_right;
		end
	end

	// Configuration register decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q          <= '0;
			straight_scale_q <= SCALE_W'(SCALE_RESET);
			turn_scale_q     <= SCALE_W'(SCALE_RESET);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_HEADING_GAIN_P: gains_q.p        <= cfg.data;
				REG_HEADING_GAIN_D: gains_q.d        <= cfg.data;
				REG_HEADING_GAIN_I: gains_q.i        <= cfg.data;
				REG_TOTAL_GAIN_P:   gains_q.t        <= cfg.data;
				REG_STRAIGHT_SCALE: straight_scale_q <= cfg.data;
				REG_TURN_SCALE:     turn_scale_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	ddpc_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (v1_q && rdy2),
		.item           (item_s1),
		.straight_scale (straight_scale_q),
		.turn_scale     (turn_scale_q),
		.trk_s2         (trk_s2)
	);

	ddpc_mult u_mult (
		.clk    (clk),
		.load   (v2_q && rdy3),
		.gains  (gains_q),
		.trk_s2 (trk_s2),
		.mul_s3 (mul_s3)
	);

	ddpc_power u_power (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (v3_q && adv_o),
		.mul_s3 (mul_s3),
		.res_q  (res_q)
	);

	// Result channel.
	assign res.valid           = vo_q;
	assign res.dir_left        = res_q.dir_l;
	assign res.dir_right       = res_q.dir_r;
	assign res.power_left      = res_q.power_l;
	assign res.power_right     = res_q.power_r;
	assign res.mode_now        = res_q.mode;
	assign res.target_counts   = res_q.target;
	assign res.progress_counts = res_q.progress;
	assign res.move_done       = res_q.done;
	assign res.reset_encoders  = res_q.clear;

endmodule

`default_nettype wire

>>> sv/ddpc_checker.sv
`default_nettype none

module ddpc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                res_valid,
	input wire logic                                res_ready,
	input wire logic [ddpc_pkg::POWER_W-1:0]        power_left,
	input wire logic [ddpc_pkg::POWER_W-1:0]        power_right,
	input wire logic [ddpc_pkg::MODE_W-1:0]         mode_now,
	input wire logic [ddpc_pkg::TARGET_W-1:0]       target_counts,
	input wire logic signed [ddpc_pkg::COUNT_BITS-1:0] progress_counts,
	input wire logic                                move_done,
	input wire logic                                reset_encoders
);
	import ddpc_pkg::*;

	// Both powers stay inside the clamp range on every result.
	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (power_left >= POWER_W'(POWER_MIN)) && (power_left <= POWER_W'(POWER_MAX))
			&& (power_right >= POWER_W'(POWER_MIN)) && (power_right <= POWER_W'(POWER_MAX)))
		else $error("motor power outside the clamp range");

	// An encoder reset request comes only with a finished move and cleared tracking.
	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && reset_encoders |-> move_done && (mode_now == MODE_STOP)
			&& (target_counts == '0) && (progress_counts == '0))
		else $error("encoder reset without a finished move");

	// A finished move leaves the block stopped until the next command.
	a_done_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && move_done |-> (mode_now == MODE_STOP))
		else $error("move done while still moving");

	// A stalled result holds its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(power_left) && $stable(power_right)
			&& $stable(target_counts) && $stable(progress_counts) && $stable(reset_encoders))
		else $error("stalled result changed");

endmodule

bind differential_drive_pid_control_top ddpc_checker u_ddpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.power_left      (res.power_left),
	.power_right     (res.power_right),
	.mode_now        (res.mode_now),
	.target_counts   (res.target_counts),
	.progress_counts (res.progress_counts),
	.move_done       (res.move_done),
	.reset_encoders  (res.reset_encoders)
);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ddpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WRAP_SHIFT     = 64 - COUNT_BITS;
	localparam longint TARGET_LIMIT = (longint'(1) << TARGET_W) - 1;
	localparam logic [MODE_W-1:0] KIND_UNUSED = 3'd7;

	bit   clk = 1'b0;
	logic arst_n;

	ddpc_cmd_if cmd_ch ();
	ddpc_res_if res_ch ();
	ddpc_cfg_if cfg_ch ();

	differential_drive_pid_control_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	// Copy of the controller state, advanced on every accepted input transfer.
	mode_t  mdl_mode     = MODE_STOP;
	longint mdl_target   = 0;
	longint mdl_progress = 0;
	bit     mdl_done     = 1'b0;
	longint mdl_prev_l   = 0;
	longint mdl_prev_r   = 0;
	longint mdl_prev_err = 0;
	longint mdl_integ    = 0;
	longint mdl_pwr_l    = POWER_RESET;
	longint mdl_pwr_r    = POWER_RESET;
	dir_t   mdl_dir_l    = DIR_STOPPED;
	dir_t   mdl_dir_r    = DIR_STOPPED;

	// Register values as last written.
	longint cfg_gain_p         = 0;
	longint cfg_gain_d         = 0;
	longint cfg_gain_i         = 0;
	longint cfg_gain_t         = 0;
	longint cfg_straight_scale = SCALE_RESET;
	longint cfg_turn_scale     = SCALE_RESET;

	res_t pending_motor_res[$];
	int   n_sent       = 0;
	int   n_checked    = 0;
	int   n_mismatch   = 0;
	int   n_settings   = 0;
	int   idle_cycles  = 0;
	bit   calm_phase   = 1'b0;

	function automatic longint wrap_count(input longint v);
		return (v <<< WRAP_SHIFT) >>> WRAP_SHIFT;
	endfunction

	function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// Mostly back-to-back, sometimes a short gap, now and then a long pause; none when calm.
	function automatic int pick_gap();
		int r;
		if (calm_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic cmd_t move_cmd(input logic [MODE_W-1:0] kind,
			input logic [AMOUNT_W-1:0] amt);
		cmd_t it;
		it.action      = 1'b1;
		it.move_kind   = kind;
		it.amount      = amt;
		it.count_left  = $urandom;
		it.count_right = $urandom;
		return it;
	endfunction

	function automatic cmd_t tick_cmd(input int l, input int r);
		cmd_t it;
		it.action      = 1'b0;
		it.move_kind   = $urandom_range(0, 7);
		it.amount      = $urandom;
		it.count_left  = l[COUNT_BITS-1:0];
		it.count_right = r[COUNT_BITS-1:0];
		return it;
	endfunction

	// Computes the motor result of one item and advances the state copy.
	function automatic res_t predict_drive(input cmd_t it);
		res_t   r;
		bit     finished;
		bit     straight;
		longint cl, cr, dl, dr, err, derr, etot, sum, half, base_l, base_r, scale, prod;
		finished = 1'b0;
		if (it.action) begin
			// Any command clears done; the unused kind does nothing else.
			mdl_done = 1'b0;
			if (it.move_kind == MODE_STOP) begin
				mdl_mode = MODE_STOP;
			end else if (it.move_kind < MODE_STOP) begin
				scale = (it.move_kind == MODE_TURN_LEFT || it.move_kind == MODE_TURN_RIGHT) ?
					cfg_turn_scale : cfg_straight_scale;
				prod = (longint'(it.amount) * scale) >>> SCALE_FRAC_BITS;
				mdl_target = (prod > TARGET_LIMIT) ? TARGET_LIMIT : prod;
				mdl_mode = mode_t'(it.move_kind);
			end
		end else if (mdl_mode == MODE_STOP) begin
			mdl_dir_l = DIR_STOPPED;
			mdl_dir_r = DIR_STOPPED;
		end else if (mdl_mode != MODE_LEFT && mdl_mode != MODE_RIGHT) begin
			straight = (mdl_mode == MODE_FORWARD || mdl_mode == MODE_BACK);
			cl = wrap_count(it.count_left);
			cr = wrap_count(it.count_right);
			dl = wrap_count(cl - mdl_prev_l);
			dr = wrap_count(cr - mdl_prev_r);
			mdl_prev_l = cl;
			mdl_prev_r = cr;
			mdl_progress = (cl + cr) / 2;
			if (mdl_progress >= mdl_target) begin
				// Target reached: stop and ask for the encoders to be cleared.
				mdl_mode = MODE_STOP;
				mdl_progress = 0;
				mdl_target = 0;
				mdl_prev_l = 0;
				mdl_prev_r = 0;
				mdl_done = 1'b1;
				finished = 1'b1;
			end else begin
				case (mdl_mode)
					MODE_FORWARD: begin
						mdl_dir_r = DIR_CW;
						mdl_dir_l = DIR_CCW;
					end
					MODE_BACK: begin
						mdl_dir_r = DIR_CCW;
						mdl_dir_l = DIR_CW;
					end
					MODE_TURN_LEFT: begin
						mdl_dir_r = DIR_CW;
						mdl_dir_l = DIR_CW;
					end
					default: begin
						mdl_dir_r = DIR_CCW;
						mdl_dir_l = DIR_CCW;
					end
				endcase
				// Heading PID with a clamped integral, half added left and taken right.
				err = dr - dl;
				derr = err - mdl_prev_err;
				mdl_prev_err = err;
				etot = straight ? (cr - cl) : 0;
				mdl_integ = clamp_range(mdl_integ + err, -INTEG_LIMIT, INTEG_LIMIT);
				sum = cfg_gain_p * err + cfg_gain_d * derr + cfg_gain_t * etot
					+ cfg_gain_i * mdl_integ;
				half = sum / (longint'(1) << HALF_SHIFT);
				base_l = straight ? STRAIGHT_BASE_POWER : mdl_pwr_l;
				base_r = straight ? STRAIGHT_BASE_POWER : mdl_pwr_r;
				mdl_pwr_r = clamp_range(base_r - half, POWER_MIN, POWER_MAX);
				mdl_pwr_l = clamp_range(base_l + half, POWER_MIN, POWER_MAX);
			end
		end
		r.dir_l    = mdl_dir_l;
		r.dir_r    = mdl_dir_r;
		r.power_l  = mdl_pwr_l[POWER_W-1:0];
		r.power_r  = mdl_pwr_r[POWER_W-1:0];
		r.mode     = mdl_mode;
		r.target   = mdl_target[TARGET_W-1:0];
		r.progress = mdl_progress[COUNT_BITS-1:0];
		r.done     = mdl_done;
		r.clear    = finished;
		return r;
	endfunction

	// Presents one item after a random gap and holds it until the transfer.
	task automatic send_drive_item(input cmd_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.action      <= it.action;
		cmd_ch.move_kind   <= it.move_kind;
		cmd_ch.amount      <= it.amount;
		cmd_ch.count_left  <= it.count_left;
		cmd_ch.count_right <= it.count_right;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_motor_res.push_back(predict_drive(it));
		n_sent++;
	endtask

	// Stops the input side and waits for every outstanding result.
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (pending_motor_res.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_setting(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_HEADING_GAIN_P: cfg_gain_p = longint'(signed'(value));
			REG_HEADING_GAIN_D: cfg_gain_d = longint'(signed'(value));
			REG_HEADING_GAIN_I: cfg_gain_i = longint'(signed'(value));
			REG_TOTAL_GAIN_P:   cfg_gain_t = longint'(signed'(value));
			REG_STRAIGHT_SCALE: cfg_straight_scale = longint'(value);
			REG_TURN_SCALE:     cfg_turn_scale = longint'(value);
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Writes the whole register set once the block has gone idle.
	task automatic apply_setting(input logic [CFG_DATA_W-1:0] gp, input logic [CFG_DATA_W-1:0] gd,
			input logic [CFG_DATA_W-1:0] gi, input logic [CFG_DATA_W-1:0] gt,
			input logic [CFG_DATA_W-1:0] ss, input logic [CFG_DATA_W-1:0] ts);
		drain_results();
		write_setting(REG_HEADING_GAIN_P, gp);
		write_setting(REG_HEADING_GAIN_D, gd);
		write_setting(REG_HEADING_GAIN_I, gi);
		write_setting(REG_TOTAL_GAIN_P, gt);
		write_setting(REG_STRAIGHT_SCALE, ss);
		write_setting(REG_TURN_SCALE, ts);
		n_settings++;
	endtask

	// After reset: a stopped tick, a zero target that ends at once, the unused kind.
	task automatic test_startup_and_zero_target();
		send_drive_item(tick_cmd(5, -3));
		send_drive_item(move_cmd(MODE_FORWARD, 16'd0));
		send_drive_item(tick_cmd(0, 0));
		send_drive_item(tick_cmd(1, 1));
		send_drive_item(move_cmd(KIND_UNUSED, 16'hFFFF));
	endtask

	// Every mode with nonzero gains, power clamps on both ends, and move completion.
	task automatic test_pid_moves();
		apply_setting(16'd512, -16'sd256, 16'd128, 16'd64, 16'd256, 16'd256);
		send_drive_item(move_cmd(MODE_FORWARD, 16'd200));
		send_drive_item(tick_cmd(10, 16));
		send_drive_item(tick_cmd(25, 20));
		send_drive_item(tick_cmd(60, 90));
		send_drive_item(tick_cmd(400, -200));
		send_drive_item(tick_cmd(210, 210));
		send_drive_item(move_cmd(MODE_BACK, 16'd50));
		send_drive_item(tick_cmd(-5, -5));
		send_drive_item(tick_cmd(60, 40));
		send_drive_item(move_cmd(MODE_TURN_LEFT, 16'd30));
		send_drive_item(tick_cmd(4, 9));
		send_drive_item(tick_cmd(8, 12));
		send_drive_item(tick_cmd(40, 40));
		send_drive_item(move_cmd(MODE_TURN_RIGHT, 16'd10));
		send_drive_item(tick_cmd(3, 1));
		send_drive_item(tick_cmd(20, 0));
		send_drive_item(move_cmd(MODE_LEFT, 16'd5));
		send_drive_item(tick_cmd(100, 100));
		send_drive_item(move_cmd(MODE_RIGHT, 16'd5));
		send_drive_item(tick_cmd(-100, 70));
		send_drive_item(move_cmd(MODE_STOP, 16'd9));
		send_drive_item(tick_cmd(7, 7));
	endtask

	// Saturated target, counts at both ends of their range, wrapped deltas.
	task automatic test_saturation_and_wrap();
		apply_setting(16'd300, 16'd100, 16'h7FFF, 16'd1, 16'hFFFF, 16'd256);
		send_drive_item(move_cmd(MODE_FORWARD, 16'hFFFF));
		send_drive_item(tick_cmd(8388607, -8388608));
		send_drive_item(tick_cmd(-8388608, 8388607));
		send_drive_item(tick_cmd(-8388608, -8388608));
		send_drive_item(move_cmd(MODE_STOP, 16'd0));
	endtask

	// Random traffic: mostly complete moves, plus sideways moves and noise.
	task automatic run_motion_traffic(input int goal);
		int                  last_item;
		int                  pick;
		int                  ticks;
		int                  cl, cr, step;
		longint              scale;
		logic [MODE_W-1:0]   kind;
		logic [AMOUNT_W-1:0] amt;
		cmd_t                it;
		last_item = n_sent + goal;
		while (n_sent < last_item) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				it.action      = $urandom_range(0, 1);
				it.move_kind   = $urandom_range(0, 7);
				it.amount      = $urandom;
				it.count_left  = $urandom;
				it.count_right = $urandom;
				send_drive_item(it);
			end else if (pick < 18) begin
				// Ticks in a sideways mode must leave everything as it was.
				kind = $urandom_range(0, 1) ? MODE_LEFT : MODE_RIGHT;
				send_drive_item(move_cmd(kind, $urandom));
				repeat ($urandom_range(1, 4)) send_drive_item(tick_cmd($urandom, $urandom));
				send_drive_item(move_cmd(MODE_STOP, $urandom));
			end else begin
				kind = $urandom_range(MODE_FORWARD, MODE_TURN_RIGHT);
				scale = (kind >= MODE_TURN_LEFT) ? cfg_turn_scale : cfg_straight_scale;
				if (scale == 0 || $urandom_range(0, 19) == 0)
					amt = $urandom;
				else
					amt = $urandom_range(0, 60000 / scale + 1);
				send_drive_item(move_cmd(kind, amt));
				// Encoders count up from zero, with some backlash and a rare slip.
				cl = 0;
				cr = 0;
				ticks = 0;
				while (mdl_mode != MODE_STOP && ticks < 30) begin
					step = $urandom_range(0, 40);
					if ($urandom_range(0, 9) == 0)
						step = -step;
					cl += step;
					cr += step + int'($urandom_range(0, 10)) - 5;
					if ($urandom_range(0, 29) == 0)
						cr += int'($urandom_range(0, 2000)) - 1000;
					send_drive_item(tick_cmd(cl, cr));
					ticks++;
				end
				if (mdl_mode != MODE_STOP && $urandom_range(0, 1))
					send_drive_item(move_cmd(MODE_STOP, $urandom));
				else if ($urandom_range(0, 1))
					send_drive_item(tick_cmd(cl, cr));
			end
		end
	endtask

	// Several register settings, the extremes among them, one phase without idling.
	task automatic test_random_phases();
		apply_setting($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
			$urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
			$urandom_range(256, 1024), $urandom_range(256, 1024));
		run_motion_traffic(150);
		apply_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		run_motion_traffic(100);
		apply_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
		run_motion_traffic(80);
		apply_setting($urandom, $urandom, $urandom, $urandom,
			$urandom_range(128, 2048), $urandom_range(128, 2048));
		calm_phase = 1'b1;
		run_motion_traffic(150);
		drain_results();
		calm_phase = 1'b0;
		apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd256);
		run_motion_traffic(80);
		apply_setting($urandom_range(0, 4095) - 2048, $urandom_range(0, 1023) - 512,
			$urandom_range(0, 255) - 128, $urandom_range(0, 1023) - 512,
			16'd256, 16'd512);
		run_motion_traffic(850 - n_sent);
	endtask

	// Result side: random stalls of the receiver.
	initial begin : result_stall
		int hold;
		hold = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (calm_phase) begin
				hold = 0;
				res_ch.ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < 25) begin
				hold = pick_gap();
				if (hold > 0) begin
					hold--;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string fname, input longint want, input longint got);
		if (want != got) begin
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("result %0d, %s: expected %0d, got %0d", n_checked, fname, want, got);
		end
	endtask

	// Compares each result transfer with the oldest expectation; counts idle cycles.
	initial begin : result_check
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1) begin
				if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
						|| (cfg_ch.valid && cfg_ch.ready))
					idle_cycles = 0;
				else
					idle_cycles++;
				if (res_ch.valid && res_ch.ready) begin
					if (pending_motor_res.size() == 0) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("result with no expectation waiting at %0t", $realtime);
					end else begin
						want = pending_motor_res.pop_front();
						check_field("dir_left", want.dir_l, res_ch.dir_left);
						check_field("dir_right", want.dir_r, res_ch.dir_right);
						check_field("power_left", want.power_l, res_ch.power_left);
						check_field("power_right", want.power_r, res_ch.power_right);
						check_field("mode_now", want.mode, res_ch.mode_now);
						check_field("target_counts", want.target, res_ch.target_counts);
						check_field("progress_counts", wrap_count(want.progress),
							wrap_count(res_ch.progress_counts));
						check_field("move_done", want.done, res_ch.move_done);
						check_field("reset_encoders", want.clear, res_ch.reset_encoders);
					end
					n_checked++;
				end
			end
		end
	end

	// Ends a run in which nothing has moved for too long.
	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("No transfer for %0d cycles, %0d results outstanding.",
			WATCHDOG_LIMIT, pending_motor_res.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : main_sequence
		arst_n             <= 1'b0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.action      <= 1'b0;
		cmd_ch.move_kind   <= MODE_STOP;
		cmd_ch.amount      <= '0;
		cmd_ch.count_left  <= '0;
		cmd_ch.count_right <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= REG_HEADING_GAIN_P;
		cfg_ch.data        <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_startup_and_zero_target();
		test_pid_moves();
		test_saturation_and_wrap();
		test_random_phases();
		drain_results();

		$display("Sent %0d items under %0d register settings; %0d results checked.",
			n_sent, n_settings, n_checked);
		$display("Covered all move kinds, stop and sideways ticks, clamps and count wrap.");
		if (n_mismatch == 0 && pending_motor_res.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d results missing.", n_mismatch,
				pending_motor_res.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
